FILE: rtl/core/bbpb_pkg.sv
// Package for the battery bus power balance block.
// Holds the divider control and status types and fixed constants; no dependencies.
`default_nettype none
package bbpb_pkg;

	typedef struct packed {
		logic       start;
		logic [6:0] nbits;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	localparam int DVD_W = 66;
	localparam int DSR_W = 30;

	// Full charge is 10000 (0.01 %) with 32 fraction bits.
	localparam logic [48:0] FULL_Q   = 49'h0_2710_0000_0000;
	localparam logic [48:0] FRAC_RST = 49'h0_1388_0000_0000;
	localparam logic [13:0] SOC_MAX  = 14'd10000;

	localparam logic [2:0] REG_CHARGE_LIMIT    = 3'd0;
	localparam logic [2:0] REG_DISCHARGE_LIMIT = 3'd1;
	localparam logic [2:0] REG_CHARGE_EFF      = 3'd2;
	localparam logic [2:0] REG_CAPACITY_WH     = 3'd3;
	localparam logic [2:0] REG_SOC_PRESET      = 3'd4;

endpackage
`default_nettype wire

FILE: rtl/core/bbpb_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on bbpb_pkg for its control and status types.
`default_nettype none
module bbpb_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire bbpb_pkg::div_ctl_t          ctl,
	input  wire logic [bbpb_pkg::DVD_W-1:0]  dividend,
	input  wire logic [bbpb_pkg::DSR_W-1:0]  divisor,
	output bbpb_pkg::div_stat_t              stat,
	output logic [bbpb_pkg::DVD_W-1:0]       quotient
);

	logic [bbpb_pkg::DVD_W-1:0] dvd_q;
	logic [bbpb_pkg::DSR_W-1:0] dsr_q;
	logic [bbpb_pkg::DSR_W-1:0] rem_q;
	logic [bbpb_pkg::DVD_W-1:0] quo_q;
	logic [6:0]                 cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [bbpb_pkg::DSR_W:0]   trial;
	logic                       ge;
	logic [bbpb_pkg::DSR_W:0]   diff;

	always_comb begin
		trial = {rem_q, dvd_q[cnt_q]};
		ge    = trial >= {1'b0, dsr_q};
		diff  = trial - {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= ctl.nbits - 7'd1;
			end else if (busy_q) begin
				if (cnt_q == 7'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 7'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[bbpb_pkg::DSR_W-1:0] : trial[bbpb_pkg::DSR_W-1:0];
			quo_q <= {quo_q[bbpb_pkg::DVD_W-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule
`default_nettype wire

FILE: rtl/core/battery_bus_power_balance.sv
// Battery bus power balance: it takes one item at a time and accepts the next only
// once the sequencer is idle again. The shared one-bit-per-cycle divider runs three
// divisions of 65, 40 and 46 quotient bits per item. A waiting result holds the
// sequencer in its last state and so the input. Asynchronous active-low reset restores
// the register defaults, sets the state of charge to 50 % and empties the output
// register. Depends on bbpb_pkg and bbpb_div.
`default_nettype none
module battery_bus_power_balance (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// solar_available[15:0], motor_request[31:16], hotel_request[47:32], step_ms[63:48]
	input  wire logic [63:0]  s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// solar_used[15:0], motor_served[31:16], hotel_served[47:32], battery_power[64:48],
	// curtailed_power[80:65], charge_level[94:81], terminal_millivolts[109:95],
	// battery_centiamps[125:110], zero fill[127:126]
	output logic [127:0]      m_tdata,
	input  wire logic         cfg_wr_en,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [16:0]  cfg_data
);

	// Sequencer states. Each item walks the whole list once.
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_BAL   = 4'd1;
	localparam logic [3:0] S_MUL1  = 4'd2;
	localparam logic [3:0] S_MUL2  = 4'd3;
	localparam logic [3:0] S_DIV1  = 4'd4;
	localparam logic [3:0] S_WAIT1 = 4'd5;
	localparam logic [3:0] S_UPD   = 4'd6;
	localparam logic [3:0] S_OCV   = 4'd7;
	localparam logic [3:0] S_DIV2  = 4'd8;
	localparam logic [3:0] S_WAIT2 = 4'd9;
	localparam logic [3:0] S_DIV3  = 4'd10;
	localparam logic [3:0] S_WAIT3 = 4'd11;
	localparam logic [3:0] S_TUV   = 4'd12;
	localparam logic [3:0] S_MV    = 4'd13;
	localparam logic [3:0] S_OUT   = 4'd14;

	// Reciprocal of 1000 with 36 fraction bits, rounded up. It gives the exact
	// floor of a division by 1000 for any value below 2^26.
	localparam logic [26:0] INV_1000 = 27'd68719477;

	logic [3:0]  state_q;

	// Configuration registers.
	logic [15:0] climit_q;
	logic [15:0] dlimit_q;
	logic [16:0] eff_q;
	logic [16:0] cap_q;

	// Persistent state: charge fraction in 0.01 % with 32 fraction bits.
	logic [48:0] frac_q;
	logic signed [16:0] last_bat_q;

	// Latched input item.
	logic [15:0] solar_q, motor_q, hotel_q, ms_q;

	// Balance results.
	logic [15:0] used_q, mserv_q, hserv_q, curt_q, pwr_q;
	logic [16:0] effsel_q;
	logic        chg_q;

	// Arithmetic working registers.
	logic [48:0] prod_q;
	logic [28:0] den_q;
	logic [24:0] ocv_q;
	logic [15:0] cur_q;
	logic [21:0] term_q;
	logic [25:0] tuv_q;
	logic [14:0] mv_q;

	bbpb_pkg::div_ctl_t  div_ctl;
	bbpb_pkg::div_stat_t div_stat;
	logic [bbpb_pkg::DVD_W-1:0] div_dvd;
	logic [bbpb_pkg::DSR_W-1:0] div_dsr;
	logic [bbpb_pkg::DVD_W-1:0] div_quo;

	bbpb_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	assign s_tready = (state_q == S_IDLE);

	// The divider operands are chosen by the state that starts it.
	always_comb begin
		div_ctl.start = 1'b0;
		div_ctl.nbits = 7'd1;
		div_dvd       = '0;
		div_dsr       = 30'd1;
		case (state_q)
			S_DIV1: begin
				div_ctl.start = 1'b1;
				div_ctl.nbits = 7'd65;
				div_dvd       = {1'b0, prod_q, 16'd0};
				div_dsr       = {1'b0, den_q};
			end
			S_DIV2: begin
				div_ctl.start = 1'b1;
				div_ctl.nbits = 7'd40;
				div_dvd       = {17'd0, prod_q};
				div_dsr       = {5'd0, ocv_q};
			end
			S_DIV3: begin
				div_ctl.start = 1'b1;
				div_ctl.nbits = 7'd46;
				div_dvd       = {17'd0, prod_q};
				div_dsr       = {5'd0, ocv_q};
			end
			default: begin
			end
		endcase
	end

	// Bus balance, worked out from the latched item and the state before the update.
	logic signed [18:0] net;
	logic [15:0] cl_eff, dl_eff;
	logic [16:0] need, rest, rest2, cut, sup;
	logic [15:0] chg;
	always_comb begin
		cl_eff = (frac_q >= bbpb_pkg::FULL_Q) ? 16'd0 : climit_q;
		dl_eff = (frac_q == 49'd0) ? 16'd0 : dlimit_q;
		net    = $signed({3'b0, solar_q}) - $signed({3'b0, motor_q})
		         - $signed({3'b0, hotel_q});
		chg    = (net[15:0] > cl_eff) ? cl_eff : net[15:0];
		need   = 17'(-net);
		sup    = (need > {1'b0, dl_eff}) ? {1'b0, dl_eff} : need;
		rest   = need - sup;
		cut    = (rest > {1'b0, motor_q}) ? {1'b0, motor_q} : rest;
		rest2  = rest - cut;
	end

	// Charge fraction after the step, with the clamp to full or empty.
	logic [65:0] frac_sum;
	logic [48:0] frac_new;
	always_comb begin
		frac_sum = {17'd0, frac_q} + div_quo;
		if (chg_q) begin
			frac_new = (frac_sum > {17'd0, bbpb_pkg::FULL_Q}) ? bbpb_pkg::FULL_Q
			                                                 : frac_sum[48:0];
		end else begin
			frac_new = (div_quo >= {17'd0, frac_q}) ? 49'd0 : frac_q - div_quo[48:0];
		end
	end

	// Open-circuit voltage, 23.5 V plus 300 uV per 0.01 %: times 300 by shifts.
	logic [57:0] frac_x300;
	assign frac_x300 = ({9'd0, frac_q} << 8) + ({9'd0, frac_q} << 5)
	                 + ({9'd0, frac_q} << 3) + ({9'd0, frac_q} << 2);

	// Terminal voltage in millivolts: the rounded microvolt figure times 1/1000.
	logic [52:0] tuv_prod;
	assign tuv_prod = 53'(tuv_q * INV_1000);

	logic [13:0] preset;
	assign preset = (cfg_data[13:0] > bbpb_pkg::SOC_MAX) ? bbpb_pkg::SOC_MAX : cfg_data[13:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid   <= 1'b0;
			climit_q   <= 16'd10000;
			dlimit_q   <= 16'd10000;
			eff_q      <= 17'd62259;
			cap_q      <= 17'd2400;
			frac_q     <= bbpb_pkg::FRAC_RST;
			last_bat_q <= '0;
		end else begin
			// The output register is loaded from the last state once it is free.
			if (state_q == S_OUT) begin
				if (!m_tvalid || m_tready) begin
					m_tvalid <= 1'b1;
				end
			end else if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					bbpb_pkg::REG_CHARGE_LIMIT:    climit_q <= cfg_data[15:0];
					bbpb_pkg::REG_DISCHARGE_LIMIT: dlimit_q <= cfg_data[15:0];
					bbpb_pkg::REG_CHARGE_EFF:      eff_q    <= cfg_data;
					bbpb_pkg::REG_CAPACITY_WH:     cap_q    <= cfg_data;
					bbpb_pkg::REG_SOC_PRESET:      frac_q   <= {3'd0, preset, 32'd0};
					default: begin
					end
				endcase
			end
			case (state_q)
				S_IDLE:  if (s_tvalid) state_q <= S_BAL;
				S_BAL:   state_q <= S_MUL1;
				S_MUL1:  state_q <= S_MUL2;
				S_MUL2:  state_q <= S_DIV1;
				S_DIV1:  state_q <= S_WAIT1;
				S_WAIT1: if (div_stat.done) state_q <= S_UPD;
				S_UPD: begin
					frac_q     <= frac_new;
					last_bat_q <= chg_q ? $signed({1'b0, pwr_q}) : -$signed({1'b0, pwr_q});
					state_q    <= S_OCV;
				end
				S_OCV:   state_q <= S_DIV2;
				S_DIV2:  state_q <= S_WAIT2;
				S_WAIT2: if (div_stat.done) state_q <= S_DIV3;
				S_DIV3:  state_q <= S_WAIT3;
				S_WAIT3: if (div_stat.done) state_q <= S_TUV;
				S_TUV:   state_q <= S_MV;
				S_MV:    state_q <= S_OUT;
				S_OUT: begin
					// The result waits here until the output register is free.
					if (!m_tvalid || m_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers; none of them needs a reset.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					solar_q <= s_tdata[15:0];
					motor_q <= s_tdata[31:16];
					hotel_q <= s_tdata[47:32];
					ms_q    <= s_tdata[63:48];
				end
			end
			S_BAL: begin
				if (!net[18]) begin
					chg_q    <= 1'b1;
					pwr_q    <= chg;
					curt_q   <= net[15:0] - chg;
					used_q   <= solar_q - (net[15:0] - chg);
					mserv_q  <= motor_q;
					hserv_q  <= hotel_q;
					effsel_q <= eff_q;
				end else begin
					chg_q    <= 1'b0;
					pwr_q    <= sup[15:0];
					curt_q   <= '0;
					used_q   <= solar_q;
					mserv_q  <= motor_q - cut[15:0];
					hserv_q  <= (rest2 > {1'b0, hotel_q}) ? 16'd0 : hotel_q - rest2[15:0];
					effsel_q <= 17'd65536;
				end
			end
			S_MUL1: begin
				prod_q <= {16'd0, 33'(pwr_q * effsel_q)};
				den_q  <= 29'(29'd3600 * ((cap_q == 17'd0) ? 17'd1 : cap_q));
			end
			S_MUL2: prod_q <= 49'(prod_q[32:0] * ms_q);
			S_OCV: begin
				ocv_q  <= 25'd23500000 + frac_x300[56:32];
				prod_q <= {9'd0, 40'(pwr_q * 24'd10000000)};
			end
			S_WAIT2: begin
				if (div_stat.done) begin
					cur_q  <= div_quo[15:0];
					prod_q <= {3'd0, 46'(pwr_q * 30'd800000000)};
				end
			end
			S_WAIT3: if (div_stat.done) term_q <= div_quo[21:0];
			S_TUV: begin
				tuv_q <= chg_q ? ({1'b0, ocv_q} + {4'd0, term_q} + 26'd500)
				               : ({1'b0, ocv_q} - {4'd0, term_q} + 26'd500);
			end
			S_MV: mv_q <= tuv_prod[50:36];
			S_OUT: begin
				if (!m_tvalid || m_tready) begin
					m_tdata <= {2'b00,
					            chg_q ? cur_q : 16'(-cur_q),
					            mv_q,
					            frac_q[45:32],
					            curt_q,
					            last_bat_q,
					            hserv_q,
					            mserv_q,
					            used_q};
				end
			end
			default: begin
			end
		endcase
	end

`ifndef ASSERT_OFF
	// The state of charge never rises above full.
	a_frac_max: assert property (@(posedge clk) disable iff (!arst_n)
		frac_q <= bbpb_pkg::FULL_Q) else $error("charge fraction above full");

	// The shared divider is never restarted while it is still working.
	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_ctl.start |-> !div_stat.busy) else $error("divider restarted while busy");

	// An accepted item always starts the balance step next.
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == S_BAL)) else $error("accept did not start");
`endif

endmodule
`default_nettype wire

FILE: verif/tb_battery_bus_power_balance.sv
// Self-checking testbench for the battery bus power balance block.
// Depends on bbpb_pkg and the battery_bus_power_balance RTL; needs no files or arguments.
`default_nettype none
module tb_battery_bus_power_balance;

	localparam longint unsigned FULL_CHARGE = 64'd10000 << 32;

	// One time step offered to the block.
	typedef struct packed {
		logic [15:0] step_ms;
		logic [15:0] hotel_request;
		logic [15:0] motor_request;
		logic [15:0] solar_available;
	} step_t;

	// One balance result, in port order from the highest bit down.
	typedef struct packed {
		logic [1:0]  fill;
		logic [15:0] battery_centiamps;
		logic [14:0] terminal_millivolts;
		logic [13:0] charge_level;
		logic [15:0] curtailed_power;
		logic [16:0] battery_power;
		logic [15:0] hotel_served;
		logic [15:0] motor_served;
		logic [15:0] solar_used;
	} balance_t;

	// A directed row: the step, and where known at a glance the expected result.
	typedef struct {
		step_t    stim;
		bit       typed;
		balance_t want;
	} row_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [63:0]  s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [127:0] m_tdata;
	logic         cfg_wr_en;
	logic [2:0]   cfg_index;
	logic [16:0]  cfg_data;

	battery_bus_power_balance dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Shadow of the block's registers and state, kept by the predictor.
	longint unsigned chg_limit, dis_limit, chg_eff, cap_wh, soc_set;
	longint unsigned soc_q;

	balance_t pending_results[$];
	int       mismatches;
	int       steps_sent;
	int       results_seen;
	bit       hold_off;       // the receiver's long stall, driven by its own process
	bit       sender_done;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Generous limit: ~630 items plus long gaps on both sides.
	initial begin
		#20000000;
		$display("FAIL");
		$finish;
	end

	task automatic report_mismatch(input string what, input longint got, input longint exp);
		$display("mismatch on %s: got %0d, expected %0d (result %0d)", what, got, exp,
			results_seen);
		mismatches++;
	endtask

	// Charge fraction change for power p over ms milliseconds, in Q32 of 0.01 %.
	function automatic longint unsigned soc_change(input longint unsigned p,
			input longint unsigned eff, input longint unsigned ms);
		longint unsigned d, num, q, r;
		d   = 3600 * (cap_wh == 0 ? 1 : cap_wh);
		num = p * eff * ms;
		q   = num / d;
		r   = num % d;
		return (q << 16) + ((r << 16) / d);
	endfunction

	function automatic void load_soc_preset();
		soc_q = (soc_set > 10000 ? 64'd10000 : soc_set) << 32;
	endfunction

	function automatic void reset_shadow();
		chg_limit = 10000;
		dis_limit = 10000;
		chg_eff   = 62259;
		cap_wh    = 2400;
		soc_set   = 5000;
		load_soc_preset();
	endfunction

	// Works out the balance for one step and advances the shadow charge state.
	function automatic balance_t balance_step(input step_t s);
		balance_t r;
		longint solar, motor, hotel, net, climit, dlimit, bat, need, sup, rest, cut;
		longint unsigned d, ocv, mag, cur, term, tuv;
		solar  = longint'(s.solar_available);
		motor  = longint'(s.motor_request);
		hotel  = longint'(s.hotel_request);
		climit = (soc_q >= FULL_CHARGE) ? 0 : longint'(chg_limit);
		dlimit = (soc_q == 0) ? 0 : longint'(dis_limit);
		net    = solar - motor - hotel;
		r = '0;
		r.solar_used   = s.solar_available;
		r.motor_served = s.motor_request;
		r.hotel_served = s.hotel_request;
		if (net >= 0) begin
			bat = net > climit ? climit : net;
			r.curtailed_power = 16'(net - bat);
			r.solar_used = 16'(solar - (net - bat));
			d = soc_change(bat, chg_eff, 64'(s.step_ms));
			soc_q += d;
			if (soc_q > FULL_CHARGE)
				soc_q = FULL_CHARGE;
		end else begin
			need = -net;
			sup  = need > dlimit ? dlimit : need;
			rest = need - sup;
			bat  = -sup;
			// Brown-out: the motor is cut first, the hotel load only after it.
			if (rest > 0) begin
				cut = rest > motor ? motor : rest;
				r.motor_served = 16'(motor - cut);
				rest -= cut;
				if (rest > 0)
					r.hotel_served = rest > hotel ? 16'd0 : 16'(hotel - rest);
			end
			d = soc_change(sup, 64'd65536, 64'(s.step_ms));
			soc_q = d >= soc_q ? 0 : soc_q - d;
		end
		ocv  = 23500000 + ((soc_q * 300) >> 32);
		mag  = bat < 0 ? -bat : bat;
		cur  = mag * 10000000 / ocv;
		term = mag * 800000000 / ocv;
		tuv  = bat < 0 ? ocv - term : ocv + term;
		r.battery_power       = 17'(bat);
		r.charge_level        = 14'(soc_q >> 32);
		r.terminal_millivolts = 15'((tuv + 500) / 1000);
		r.battery_centiamps   = 16'(bat < 0 ? -longint'(cur) : longint'(cur));
		return r;
	endfunction

	// Writes one register; the enable is low again before the task returns, so writes never overlap.
	task automatic write_reg(input logic [2:0] idx, input logic [16:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
		bbpb_pkg::REG_CHARGE_LIMIT:    chg_limit = 64'(val[15:0]);
		bbpb_pkg::REG_DISCHARGE_LIMIT: dis_limit = 64'(val[15:0]);
		bbpb_pkg::REG_CHARGE_EFF:      chg_eff   = 64'(val);
		bbpb_pkg::REG_CAPACITY_WH:     cap_wh    = 64'(val);
		bbpb_pkg::REG_SOC_PRESET: begin
			soc_set = 64'(val[13:0]);
			load_soc_preset();
		end
		default: ;
		endcase
		@(posedge clk);
	endtask

	// Every step yields a result, so an empty queue means the block is idle.
	task automatic wait_idle();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic int short_or_long_gap();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) : $urandom_range(0, 3);
	endfunction

	// Offers one step, holding valid until accepted; predicts at acceptance.
	// Valid always drops after an acceptance before the next offer is made.
	task automatic send_step(input step_t s, input bit typed, input balance_t want,
			input bit gaps);
		balance_t exp;
		int g;
		g = gaps ? short_or_long_gap() : 0;
		repeat (g + 1) @(posedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= s;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		s_tvalid <= 1'b0;
		exp = balance_step(s);
		if (typed && exp != want)
			report_mismatch("directed table entry", 1, 0);
		pending_results.push_back(typed ? want : exp);
		steps_sent++;
	endtask

	function automatic step_t random_step();
		step_t s;
		int mode;
		s = {$urandom, $urandom};
		mode = $urandom_range(0, 3);
		// Mostly moderate powers so that charge, discharge and cuts all occur.
		if (mode != 0) begin
			s.solar_available = 16'($urandom_range(0, 30000));
			s.motor_request   = 16'($urandom_range(0, 20000));
			s.hotel_request   = 16'($urandom_range(0, 8000));
			s.step_ms         = ($urandom_range(0, 7) == 0) ? 16'd0
			                                                 : 16'($urandom_range(1, 65535));
		end
		return s;
	endfunction

	task automatic random_phase(input int n);
		repeat (n)
			send_step(random_step(), 1'b0, '0, 1'b1);
	endtask

	// Receiver: random stalls, plus a long hold-off requested by the sender.
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off)
				m_tready <= 1'b0;
			else if ($urandom_range(0, 3) == 0)
				m_tready <= ~m_tready;
			else
				m_tready <= ($urandom_range(0, 19) != 0) || m_tready;
		end
	end

	// Checker: compares each accepted result with the oldest expectation.
	always @(posedge clk) begin
		balance_t got, exp;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			results_seen++;
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				exp = pending_results.pop_front();
				if (got.solar_used != exp.solar_used)
					report_mismatch("solar_used", longint'(got.solar_used),
						longint'(exp.solar_used));
				if (got.motor_served != exp.motor_served)
					report_mismatch("motor_served", longint'(got.motor_served),
						longint'(exp.motor_served));
				if (got.hotel_served != exp.hotel_served)
					report_mismatch("hotel_served", longint'(got.hotel_served),
						longint'(exp.hotel_served));
				if (got.battery_power != exp.battery_power)
					report_mismatch("battery_power", longint'($signed(got.battery_power)),
						longint'($signed(exp.battery_power)));
				if (got.curtailed_power != exp.curtailed_power)
					report_mismatch("curtailed_power", longint'(got.curtailed_power),
						longint'(exp.curtailed_power));
				if (got.charge_level != exp.charge_level)
					report_mismatch("charge_level", longint'(got.charge_level),
						longint'(exp.charge_level));
				if (got.terminal_millivolts != exp.terminal_millivolts)
					report_mismatch("terminal_millivolts", longint'(got.terminal_millivolts),
						longint'(exp.terminal_millivolts));
				if (got.battery_centiamps != exp.battery_centiamps)
					report_mismatch("battery_centiamps",
						longint'($signed(got.battery_centiamps)),
						longint'($signed(exp.battery_centiamps)));
				if (got.fill != 2'b00)
					report_mismatch("zero fill", longint'(got.fill), 0);
			end
		end
	end

	// Builds a typed result row with no battery activity at a given charge level.
	function automatic balance_t idle_result(input logic [15:0] solar, input logic [15:0] motor,
			input logic [15:0] hotel, input logic [13:0] level, input logic [14:0] mv);
		balance_t r;
		r = '0;
		r.solar_used = solar;
		r.motor_served = motor;
		r.hotel_served = hotel;
		r.charge_level = level;
		r.terminal_millivolts = mv;
		return r;
	endfunction

	row_t directed[$];

	task automatic add_row(input step_t s, input bit typed, input balance_t want);
		row_t r;
		r.stim = s;
		r.typed = typed;
		r.want = want;
		directed.push_back(r);
	endtask

	initial begin
		step_t s;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		cfg_wr_en  = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		hold_off   = 1'b0;
		sender_done = 1'b0;
		mismatches = 0;
		steps_sent = 0;
		results_seen = 0;
		reset_shadow();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table. Balanced loads after reset: 50 %, 25.000 V, nothing flows.
		add_row('0, 1'b1, idle_result(16'd0, 16'd0, 16'd0, 14'd5000, 15'd25000));
		add_row({16'd1000, 16'd300, 16'd700, 16'd1000}, 1'b1,
			idle_result(16'd1000, 16'd700, 16'd300, 14'd5000, 15'd25000));
		// Zero step length: a large surplus, charge unchanged.
		add_row({16'd0, 16'd0, 16'd0, 16'hFFFF}, 1'b0, '0);
		// Surplus above the charge limit is curtailed.
		add_row({16'd1000, 16'd0, 16'd0, 16'hFFFF}, 1'b0, '0);
		// Deficit beyond the discharge limit cuts motor, then hotel.
		add_row({16'd1000, 16'hFFFF, 16'd0, 16'd0}, 1'b0, '0);
		add_row({16'd1000, 16'hFFFF, 16'hFFFF, 16'd0}, 1'b0, '0);
		add_row({16'd1000, 16'd0, 16'hFFFF, 16'd5}, 1'b0, '0);
		add_row({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, '0);
		add_row({16'hFFFF, 16'h5555, 16'hAAAA, 16'hAAAA}, 1'b0, '0);
		add_row({16'h5555, 16'hAAAA, 16'h5555, 16'h5555}, 1'b0, '0);
		foreach (directed[i])
			send_step(directed[i].stim, directed[i].typed, directed[i].want, 1'b0);
		wait_idle();

		// Near full: small capacity, efficiency at and above one, long charge steps.
		write_reg(bbpb_pkg::REG_CAPACITY_WH, 17'd0);          // treated as one watt hour
		write_reg(bbpb_pkg::REG_CHARGE_EFF, 17'd65536);
		write_reg(bbpb_pkg::REG_SOC_PRESET, 17'd16383);       // above full loads 100 %
		write_reg(3'd7, 17'h1FFFF);                           // unknown index, ignored
		s = {16'hFFFF, 16'd0, 16'd0, 16'hFFFF};
		send_step(s, 1'b0, '0, 1'b0);                         // full battery takes no charge
		wait_idle();
		write_reg(bbpb_pkg::REG_SOC_PRESET, 17'd9999);
		send_step(s, 1'b0, '0, 1'b0);                         // clamp at full
		wait_idle();
		write_reg(bbpb_pkg::REG_CHARGE_EFF, 17'h1FFFF);
		write_reg(bbpb_pkg::REG_SOC_PRESET, 17'd9990);
		send_step(s, 1'b0, '0, 1'b0);
		wait_idle();
		// Empty: no discharge, so the loads are cut.
		write_reg(bbpb_pkg::REG_SOC_PRESET, 17'd0);
		send_step({16'hFFFF, 16'h1234, 16'd0, 16'd0}, 1'b0, '0, 1'b0);
		wait_idle();
		write_reg(bbpb_pkg::REG_SOC_PRESET, 17'd1);
		send_step({16'hFFFF, 16'd0, 16'hFFFF, 16'd0}, 1'b0, '0, 1'b0);   // drains to zero
		wait_idle();

		// Random phases across several register settings, extremes included.
		write_reg(bbpb_pkg::REG_CHARGE_LIMIT, 17'hFFFF);
		write_reg(bbpb_pkg::REG_DISCHARGE_LIMIT, 17'hFFFF);
		write_reg(bbpb_pkg::REG_CHARGE_EFF, 17'd0);
		write_reg(bbpb_pkg::REG_CAPACITY_WH, 17'd100000);
		write_reg(bbpb_pkg::REG_SOC_PRESET, 17'd5000);
		random_phase(100);
		wait_idle();
		write_reg(bbpb_pkg::REG_CHARGE_LIMIT, 17'd0);
		write_reg(bbpb_pkg::REG_DISCHARGE_LIMIT, 17'd0);
		write_reg(bbpb_pkg::REG_CHARGE_EFF, 17'd62259);
		write_reg(bbpb_pkg::REG_CAPACITY_WH, 17'd1);
		random_phase(80);
		wait_idle();
		write_reg(bbpb_pkg::REG_CHARGE_LIMIT, 17'd10000);
		write_reg(bbpb_pkg::REG_DISCHARGE_LIMIT, 17'd10000);
		write_reg(bbpb_pkg::REG_CHARGE_EFF, 17'd65536);
		write_reg(bbpb_pkg::REG_CAPACITY_WH, 17'd2);
		write_reg(bbpb_pkg::REG_SOC_PRESET, 17'd500);
		random_phase(120);
		wait_idle();
		// Long receiver hold-off while the sender keeps offering items.
		fork
			begin
				hold_off = 1'b1;
				repeat (2000) @(posedge clk);
				hold_off = 1'b0;
			end
			repeat (10) send_step(random_step(), 1'b0, '0, 1'b0);
		join
		wait_idle();
		for (int k = 0; k < 6; k++) begin
			write_reg(bbpb_pkg::REG_CHARGE_LIMIT, 17'($urandom));
			write_reg(bbpb_pkg::REG_DISCHARGE_LIMIT, 17'($urandom));
			write_reg(bbpb_pkg::REG_CHARGE_EFF, 17'($urandom_range(0, 131071)));
			write_reg(bbpb_pkg::REG_CAPACITY_WH, 17'($urandom_range(0, 5000)));
			write_reg(bbpb_pkg::REG_SOC_PRESET, 17'($urandom_range(0, 16383)));
			random_phase(50);
			wait_idle();
		end
		sender_done = 1'b1;
	end

	// End of run: after all stimulus, drain, then allow the block's latency.
	initial begin
		wait (sender_done);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
		$display("Run covered %0d steps and %0d results over charge, discharge, curtailment,",
			steps_sent, results_seen);
		$display("brown-out cuts, full and empty clamps and several register settings.");
		if (mismatches == 0 && pending_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
`default_nettype wire
